FILE: rtl/dfat_pkg.sv
// ---------------------------------------------------------------------------
// dfat_pkg
// Shared types, constants and helper functions of the Delaunay flip
// angle test: point and item formats, verdict codes, CORDIC step angles.
// ---------------------------------------------------------------------------
package dfat_pkg;

    // Number of CORDIC vectoring steps per angle.
    localparam int CORDIC_ITERATIONS = 30;

    // Steps of the digit-by-digit square root (two radicand bits per step).
    localparam int SQRT_STEPS = 32;

    // Register stages of an angle unit, from an item entering it to its angle leaving it.
    localparam int ANGLE_LAT = 11 + SQRT_STEPS + CORDIC_ITERATIONS;

    // Q2.29 constants.
    localparam logic [30:0] Q29_PI      = 31'd1686629713;
    localparam logic [30:0] Q29_HALF_PI = 31'd843314857;

    // One point, Q16.16 coordinates.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    // One flip candidate as it travels from the front to the back end.
    typedef struct packed {
        point_t v0;
        point_t v1;
        point_t v2;
        point_t v3;
        logic   degen;
    } item_t;

    // Verdict codes.
    typedef enum logic [2:0] {
        VERDICT_ACCEPTED  = 3'd0,
        VERDICT_DELAUNAY  = 3'd1,
        VERDICT_FOLD_V0   = 3'd2,
        VERDICT_FOLD_V1   = 3'd3,
        VERDICT_DEGENERATE = 3'd4
    } verdict_t;

    // Position of the highest set bit; zero for a zero word.
    function automatic logic [5:0] msb_index(input logic [63:0] v);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

    // CORDIC step angle round(atan(2^-i) * 2^29).
    function automatic logic [30:0] step_angle(input int i);
        logic [30:0] r;
        case (i)
            0:       r = 31'd421657428;
            1:       r = 31'd248918915;
            2:       r = 31'd131521918;
            3:       r = 31'd66762579;
            4:       r = 31'd33510843;
            5:       r = 31'd16771758;
            6:       r = 31'd8387925;
            7:       r = 31'd4194219;
            8:       r = 31'd2097141;
            9:       r = 31'd1048575;
            default: r = (i <= 29) ? (31'd1 << (29 - i)) : 31'd0;
        endcase
        return r;
    endfunction

    // Two points coincide.
    function automatic logic same_point(input point_t p, input point_t q);
        return (p.x == q.x) && (p.y == q.y) && (p.z == q.z);
    endfunction

endpackage

FILE: rtl/dfat_queue.sv
// ---------------------------------------------------------------------------
// dfat_queue
// Four-entry queue of flip candidates between the front end and the
// angle pipeline.
// ---------------------------------------------------------------------------
module dfat_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dfat_pkg::item_t push_data,
    input  logic           pop,
    output dfat_pkg::item_t pop_data,
    output logic           empty,
    output logic           full
);

    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    dfat_pkg::item_t mem [0:3];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign empty    = (count_reg == 3'd0);
    assign full     = (count_reg == 3'd4);

endmodule

FILE: rtl/dfat_front.sv
// ---------------------------------------------------------------------------
// dfat_front
// Input stage: takes one candidate per beat, flags zero-length edges and
// hands the classified item to the queue.
// ---------------------------------------------------------------------------
module dfat_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  dfat_pkg::point_t v0,
    input  dfat_pkg::point_t v1,
    input  dfat_pkg::point_t v2,
    input  dfat_pkg::point_t v3,
    input  logic            q_full,
    output logic            q_push,
    output dfat_pkg::item_t q_data
);

    logic            valid_reg;
    logic            valid_next;
    logic            load;
    dfat_pkg::item_t item_reg;
    dfat_pkg::item_t item_next;

    // Hand-off to the queue and input flow control.
    assign q_push   = valid_reg && !q_full;
    assign in_stall = valid_reg && q_full;
    assign load     = in_valid && !in_stall;

    // Degenerate test: any edge of length zero that the angles use.
    always_comb
    begin
        item_next.v0    = v0;
        item_next.v1    = v1;
        item_next.v2    = v2;
        item_next.v3    = v3;
        item_next.degen = dfat_pkg::same_point(v0, v1) || dfat_pkg::same_point(v0, v2) ||
                          dfat_pkg::same_point(v0, v3) || dfat_pkg::same_point(v1, v2) ||
                          dfat_pkg::same_point(v1, v3);
        valid_next      = load || (valid_reg && !q_push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign q_data = item_reg;

endmodule

FILE: rtl/dfat_angle.sv
// ---------------------------------------------------------------------------
// dfat_angle
// Pipelined angle unit: angle at m between s and q as Q2.29 radians, via
// vector normalization, cross and dot products, square root and CORDIC.
// ---------------------------------------------------------------------------
module dfat_angle (
    input  logic             clk,
    input  logic             en,
    input  dfat_pkg::point_t s,
    input  dfat_pkg::point_t m,
    input  dfat_pkg::point_t q,
    output logic [30:0]      angle
);

    localparam int N  = dfat_pkg::CORDIC_ITERATIONS;
    localparam int SQ = dfat_pkg::SQRT_STEPS;

    // Stage 1: difference vectors, a in 0..2, b in 3..5.
    logic signed [32:0] d1_reg [0:5];
    // Stage 2: differences with the leading-one position of each vector.
    logic signed [32:0] d2_reg [0:5];
    logic [5:0]         msb_a_reg;
    logic [5:0]         msb_b_reg;
    // Stage 3: normalized components.
    logic signed [30:0] n_reg [0:5];
    // Stage 4: partial products.
    logic signed [61:0] p_reg [0:8];
    // Stage 5: cross components and dot.
    logic signed [63:0] w_reg [0:3];
    // Stage 6: same with their common leading-one position.
    logic signed [63:0] w6_reg [0:3];
    logic [5:0]         msb_w_reg;
    // Stage 7: scaled cross magnitudes and dot.
    logic [30:0]        c_reg [0:2];
    logic signed [31:0] dot7_reg;
    // Stage 8: squares.
    logic [61:0]        sq_reg [0:2];
    logic signed [31:0] dot8_reg;
    // Stage 9: sum of squares.
    logic [63:0]        ss_reg;
    logic signed [31:0] dot9_reg;
    // Square root stages.
    logic [35:0]        rem_reg  [0:SQ];
    logic [31:0]        root_reg [0:SQ];
    logic [63:0]        num_reg  [0:SQ];
    logic signed [31:0] dotq_reg [0:SQ];
    // CORDIC stages.
    logic signed [35:0] cx_reg [0:N];
    logic signed [35:0] cy_reg [0:N];
    logic signed [32:0] cz_reg [0:N];
    logic [30:0]        angle_reg;

    // Stage 1 inputs.
    logic signed [32:0] d1_next [0:5];
    // Stage 2 inputs.
    logic [32:0]        or_a;
    logic [32:0]        or_b;
    // Stage 3 inputs.
    logic signed [30:0] n_next [0:5];
    // Stage 6 inputs.
    logic [63:0]        or_w;
    // Stage 7 inputs.
    logic [30:0]        c_next [0:2];
    logic signed [31:0] dot7_next;

    // Magnitude of a difference component.
    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // Magnitude of a product sum.
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Difference vectors.
    always_comb
    begin
        d1_next[0] = 33'(s.x) - 33'(m.x);
        d1_next[1] = 33'(s.y) - 33'(m.y);
        d1_next[2] = 33'(s.z) - 33'(m.z);
        d1_next[3] = 33'(q.x) - 33'(m.x);
        d1_next[4] = 33'(q.y) - 33'(m.y);
        d1_next[5] = 33'(q.z) - 33'(m.z);
    end

    // Leading-one search of each vector uses the OR of its magnitudes.
    always_comb
    begin
        or_a = mag33(d1_reg[0]) | mag33(d1_reg[1]) | mag33(d1_reg[2]);
        or_b = mag33(d1_reg[3]) | mag33(d1_reg[4]) | mag33(d1_reg[5]);
    end

    // Scale each vector so its largest magnitude lies in [2^29, 2^30).
    always_comb
    begin
        logic [32:0] mg;
        logic [32:0] t;
        logic [5:0]  sh;
        for (int j = 0; j < 6; j++) begin
            mg = mag33(d2_reg[j]);
            sh = (j < 3) ? msb_a_reg : msb_b_reg;
            if (sh > 6'd29)
            begin
                t = mg >> (sh - 6'd29);
            end
            else
            begin
                t = mg << (6'd29 - sh);
            end
            n_next[j] = d2_reg[j][32] ? -$signed({1'b0, t[29:0]}) : $signed({1'b0, t[29:0]});
        end
    end

    // Common leading-one position of cross and dot.
    assign or_w = mag64(w_reg[0]) | mag64(w_reg[1]) | mag64(w_reg[2]) | mag64(w_reg[3]);

    // Scale cross and dot together below 2^31.
    always_comb
    begin
        logic [5:0]  sh;
        logic [63:0] t;
        sh = (msb_w_reg > 6'd30) ? (msb_w_reg - 6'd30) : 6'd0;
        for (int j = 0; j < 3; j++) begin
            t         = mag64(w6_reg[j]) >> sh;
            c_next[j] = t[30:0];
        end
        t         = mag64(w6_reg[3]) >> sh;
        dot7_next = w6_reg[3][63] ? -$signed(t[31:0]) : $signed(t[31:0]);
    end

    // Front stages up to the sum of squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 6; j++) begin
                d1_reg[j] <= d1_next[j];
                d2_reg[j] <= d1_reg[j];
                n_reg[j]  <= n_next[j];
            end
            msb_a_reg <= dfat_pkg::msb_index({31'd0, or_a});
            msb_b_reg <= dfat_pkg::msb_index({31'd0, or_b});

            p_reg[0] <= n_reg[1] * n_reg[5];
            p_reg[1] <= n_reg[2] * n_reg[4];
            p_reg[2] <= n_reg[2] * n_reg[3];
            p_reg[3] <= n_reg[0] * n_reg[5];
            p_reg[4] <= n_reg[0] * n_reg[4];
            p_reg[5] <= n_reg[1] * n_reg[3];
            p_reg[6] <= n_reg[0] * n_reg[3];
            p_reg[7] <= n_reg[1] * n_reg[4];
            p_reg[8] <= n_reg[2] * n_reg[5];

            w_reg[0] <= 64'(p_reg[0]) - 64'(p_reg[1]);
            w_reg[1] <= 64'(p_reg[2]) - 64'(p_reg[3]);
            w_reg[2] <= 64'(p_reg[4]) - 64'(p_reg[5]);
            w_reg[3] <= 64'(p_reg[6]) + 64'(p_reg[7]) + 64'(p_reg[8]);

            for (int j = 0; j < 4; j++) begin
                w6_reg[j] <= w_reg[j];
            end
            msb_w_reg <= dfat_pkg::msb_index(or_w);

            for (int j = 0; j < 3; j++) begin
                c_reg[j]  <= c_next[j];
                sq_reg[j] <= c_reg[j] * c_reg[j];
            end
            dot7_reg <= dot7_next;
            dot8_reg <= dot7_reg;

            ss_reg   <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            dot9_reg <= dot8_reg;
        end
    end

    // Square root, two radicand bits per stage.
    always_comb
    begin
        rem_reg[0]  = 36'd0;
        root_reg[0] = 32'd0;
        num_reg[0]  = ss_reg;
        dotq_reg[0] = dot9_reg;
    end

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        logic [35:0] remx;
        logic [35:0] trial;
        assign remx  = {rem_reg[k][33:0], num_reg[k][63:62]};
        assign trial = {2'b00, root_reg[k], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (remx >= trial)
                begin
                    rem_reg[k+1]  <= remx - trial;
                    root_reg[k+1] <= {root_reg[k][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= remx;
                    root_reg[k+1] <= {root_reg[k][30:0], 1'b0};
                end
                num_reg[k+1]  <= {num_reg[k][61:0], 2'b00};
                dotq_reg[k+1] <= dotq_reg[k];
            end
        end
    end

    // Quarter-turn pre-rotation for an obtuse angle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dotq_reg[SQ][31])
            begin
                cx_reg[0] <= 36'({4'd0, root_reg[SQ]});
                cy_reg[0] <= -36'(dotq_reg[SQ]);
                cz_reg[0] <= 33'({2'b00, dfat_pkg::Q29_HALF_PI});
            end
            else
            begin
                cx_reg[0] <= 36'(dotq_reg[SQ]);
                cy_reg[0] <= 36'({4'd0, root_reg[SQ]});
                cz_reg[0] <= 33'd0;
            end
        end
    end

    // CORDIC vectoring, one step per stage.
    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [35:0] dx;
        logic signed [35:0] dy;
        logic signed [32:0] da;
        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        assign da = 33'({2'b00, dfat_pkg::step_angle(i)});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cy_reg[i] > 36'sd0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + da;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - da;
                end
            end
        end
    end

    // Clamp to [0, pi].
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cz_reg[N][32])
            begin
                angle_reg <= 31'd0;
            end
            else if (cz_reg[N][31:0] > {1'b0, dfat_pkg::Q29_PI})
            begin
                angle_reg <= dfat_pkg::Q29_PI;
            end
            else
            begin
                angle_reg <= cz_reg[N][30:0];
            end
        end
    end

    assign angle = angle_reg;

endmodule

FILE: rtl/delaunay_flip_angle_test.sv
// ---------------------------------------------------------------------------
// delaunay_flip_angle_test
// Delaunay edge-flip angle test: six angles per candidate, then the
// Delaunay and foldover verdicts.
//
//   channel   direction  handshake                fields
//   input     in         in_valid / in_stall      edge_a_*, edge_b_*, opp_c_*, opp_d_*
//   output    out        out_valid / out_stall    flip_accepted, verdict
//   config    in         cfg_we                   cfg_wdata (angle tolerance)
//
// One candidate is taken per cycle while in_stall is low. A result passes the
// input register, the queue, the angle pipeline (square root stages plus
// one stage per CORDIC step) and the output register. Reset clears the
// pipeline valid bits, the queue and sets the tolerance to 1. A stall on the
// output while a result is held freezes the angle pipeline; the four-entry
// queue keeps taking beats until it fills.
// ---------------------------------------------------------------------------
module delaunay_flip_angle_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] edge_a_x,
    input  logic signed [31:0] edge_a_y,
    input  logic signed [31:0] edge_a_z,
    input  logic signed [31:0] edge_b_x,
    input  logic signed [31:0] edge_b_y,
    input  logic signed [31:0] edge_b_z,
    input  logic signed [31:0] opp_c_x,
    input  logic signed [31:0] opp_c_y,
    input  logic signed [31:0] opp_c_z,
    input  logic signed [31:0] opp_d_x,
    input  logic signed [31:0] opp_d_y,
    input  logic signed [31:0] opp_d_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               flip_accepted,
    output logic [2:0]         verdict
);

    localparam int LAT = dfat_pkg::ANGLE_LAT;

    logic [15:0]        tol_reg;
    dfat_pkg::point_t   p0;
    dfat_pkg::point_t   p1;
    dfat_pkg::point_t   p2;
    dfat_pkg::point_t   p3;
    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic               q_full;
    dfat_pkg::item_t    q_in;
    dfat_pkg::item_t    q_out;
    logic               adv;
    logic               vld_reg [0:LAT-1];
    logic               dg_reg  [0:LAT-1];
    logic [30:0]        ang [0:5];
    logic               out_valid_reg;
    dfat_pkg::verdict_t verdict_reg;
    dfat_pkg::verdict_t verdict_next;
    logic [31:0]        sum_opp;
    logic [31:0]        sum_v0;
    logic [31:0]        sum_v1;
    logic [31:0]        lim_hi;
    logic [31:0]        lim_lo;

    // Tolerance register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    assign p0 = '{x: edge_a_x, y: edge_a_y, z: edge_a_z};
    assign p1 = '{x: edge_b_x, y: edge_b_y, z: edge_b_z};
    assign p2 = '{x: opp_c_x, y: opp_c_y, z: opp_c_z};
    assign p3 = '{x: opp_d_x, y: opp_d_y, z: opp_d_z};

    // Front end: takes beats and flags degenerate candidates.
    dfat_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .v0       (p0),
        .v1       (p1),
        .v2       (p2),
        .v3       (p3),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    dfat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .full      (q_full)
    );

    // The back end advances unless a finished result is held against a stall.
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = adv && !q_empty;

    // Six angle units: opposite vertices, then at v0, then at v1.
    dfat_angle u_ang0 (.clk(clk), .en(adv), .s(q_out.v0), .m(q_out.v2), .q(q_out.v1),
                       .angle(ang[0]));
    dfat_angle u_ang1 (.clk(clk), .en(adv), .s(q_out.v0), .m(q_out.v3), .q(q_out.v1),
                       .angle(ang[1]));
    dfat_angle u_ang2 (.clk(clk), .en(adv), .s(q_out.v3), .m(q_out.v0), .q(q_out.v1),
                       .angle(ang[2]));
    dfat_angle u_ang3 (.clk(clk), .en(adv), .s(q_out.v2), .m(q_out.v0), .q(q_out.v1),
                       .angle(ang[3]));
    dfat_angle u_ang4 (.clk(clk), .en(adv), .s(q_out.v3), .m(q_out.v1), .q(q_out.v0),
                       .angle(ang[4]));
    dfat_angle u_ang5 (.clk(clk), .en(adv), .s(q_out.v2), .m(q_out.v1), .q(q_out.v0),
                       .angle(ang[5]));

    // Valid and degenerate flags travel alongside the angle pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= !q_empty;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dg_reg[0] <= q_out.degen;
            for (int i = 1; i < LAT; i++) begin
                dg_reg[i] <= dg_reg[i-1];
            end
        end
    end

    // Verdict from the angle sums.
    always_comb
    begin
        sum_opp = {1'b0, ang[0]} + {1'b0, ang[1]};
        sum_v0  = {1'b0, ang[2]} + {1'b0, ang[3]};
        sum_v1  = {1'b0, ang[4]} + {1'b0, ang[5]};
        lim_hi  = {1'b0, dfat_pkg::Q29_PI} + {16'd0, tol_reg};
        lim_lo  = {1'b0, dfat_pkg::Q29_PI} - {16'd0, tol_reg};
        if (dg_reg[LAT-1])
        begin
            verdict_next = dfat_pkg::VERDICT_DEGENERATE;
        end
        else if (sum_opp <= lim_hi)
        begin
            verdict_next = dfat_pkg::VERDICT_DELAUNAY;
        end
        else if (sum_v0 >= lim_lo)
        begin
            verdict_next = dfat_pkg::VERDICT_FOLD_V0;
        end
        else if (sum_v1 >= lim_lo)
        begin
            verdict_next = dfat_pkg::VERDICT_FOLD_V1;
        end
        else
        begin
            verdict_next = dfat_pkg::VERDICT_ACCEPTED;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = verdict_reg;
    assign flip_accepted = (verdict_reg == dfat_pkg::VERDICT_ACCEPTED);

endmodule
